@@ hw/rtl/lph_pkg.sv @@
// ----------------------------------------------------------------------------
// lph_pkg
// Shared types and constants for the linear probing hash set.
// ----------------------------------------------------------------------------
`default_nettype none

package lph_pkg;

  localparam int TABLE_SLOTS = 43;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int KEY_W       = 32;
  localparam int MODE_W      = 2;
  localparam int STATUS_W    = 3;
  localparam int IDX_W       = 6;
  localparam int DIGIT_W     = 4;
  localparam int HASH_STEPS  = KEY_W / DIGIT_W;
  localparam int HCNT_W      = $clog2(HASH_STEPS);

  typedef enum logic [MODE_W-1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_SPARE  = 2'd3
  } lph_mode_e;

  typedef enum logic [STATUS_W-1:0] {
    RES_INSERTED  = 3'd0,
    RES_PRESENT   = 3'd1,
    RES_FULL      = 3'd2,
    RES_FOUND     = 3'd3,
    RES_NOT_FOUND = 3'd4,
    RES_DELETED   = 3'd5
  } lph_status_e;

  typedef enum logic [1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_LIVE  = 2'd1,
    SLOT_TOMB  = 2'd2,
    SLOT_SPARE = 2'd3
  } lph_slot_e;

  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic signed [KEY_W-1:0] key_value;
  } lph_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [IDX_W-1:0]        slot_index;
    logic signed [KEY_W-1:0] key_echo;
  } lph_out_t;

  typedef struct packed {
    logic load;
    logic hash_step;
    logic advance;
    logic probe_eval;
    logic commit;
  } lph_cmd_t;

  typedef struct packed {
    logic hash_last;
    logic probe_stop;
    logic probe_last;
  } lph_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/lph_ctrl.sv @@
// ----------------------------------------------------------------------------
// lph_ctrl
// Sequencer: hash digits, prime the slot read, walk the probe, commit.
// ----------------------------------------------------------------------------
`default_nettype none

module lph_ctrl import lph_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire lph_sts_t sts,
  output lph_cmd_t      cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_HASH   = 5'b00010,
    S_FIRST  = 5'b00100,
    S_PROBE  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash_step = 1'b1;
        if (sts.hash_last) begin
          state_nxt = S_FIRST;
        end
      end
      S_FIRST: begin
        cmd.advance = 1'b1;
        state_nxt   = S_PROBE;
      end
      S_PROBE: begin
        cmd.probe_eval = 1'b1;
        cmd.advance    = 1'b1;
        if (sts.probe_stop || sts.probe_last) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.commit = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

@@ hw/rtl/lph_dp.sv @@
// ----------------------------------------------------------------------------
// lph_dp
// Datapath: key and mode registers, digit-serial home slot, slot tables,
// probe evaluation and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lph_dp import lph_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire lph_in_t  in_data,
  input  wire lph_cmd_t cmd,
  output lph_sts_t      sts,
  output logic          out_valid,
  output lph_out_t      out_data
);

  localparam int V_W = SLOT_W + DIGIT_W;
  localparam int DMAX = (1 << DIGIT_W) - 1;

  logic [MODE_W-1:0]   mode_r;
  logic [KEY_W-1:0]    key_r;
  logic [KEY_W-1:0]    mag_r;
  logic [HCNT_W-1:0]   hcnt_r;
  logic [SLOT_W-1:0]   addr_r;
  logic [SLOT_W-1:0]   chk_r;
  logic [SLOT_W-1:0]   pcnt_r;
  logic [SLOT_W-1:0]   rem_nxt;
  logic [SLOT_W-1:0]   addr_inc;

  logic [KEY_W-1:0]    key_mem [TABLE_SLOTS];
  logic [1:0]          state_mem [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0] valid_r;
  logic [KEY_W-1:0]    rd_key_r;
  logic [1:0]          rd_state_r;
  logic                rd_valid_r;

  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [SLOT_W-1:0]   res_slot_r, res_slot_nxt;
  logic                wr_en_r, wr_en_nxt;
  logic                wr_key_r, wr_key_nxt;
  logic                out_valid_r;
  lph_out_t            out_data_r;

  logic is_insert, is_delete, is_empty, is_live, is_match, hit;

  // remainder step: (r * 16 + digit) mod TABLE_SLOTS
  always_comb begin
    logic [V_W-1:0] v;
    logic [V_W-1:0] r;
    v = {addr_r, mag_r[KEY_W-1 -: DIGIT_W]};
    r = v;
    for (int j = 1; j <= DMAX; j++) begin
      if (v >= V_W'(j * TABLE_SLOTS)) begin
        r = v - V_W'(j * TABLE_SLOTS);
      end
    end
    rem_nxt = r[SLOT_W-1:0];
  end

  assign addr_inc = (addr_r == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : addr_r + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_data.mode;
      key_r  <= in_data.key_value;
      mag_r  <= in_data.key_value[KEY_W-1] ? (KEY_W'(0) - in_data.key_value)
                                           : in_data.key_value;
      hcnt_r <= '0;
      addr_r <= '0;
      pcnt_r <= '0;
    end else if (cmd.hash_step) begin
      mag_r  <= {mag_r[KEY_W-DIGIT_W-1:0], DIGIT_W'(0)};
      hcnt_r <= hcnt_r + 1'b1;
      addr_r <= rem_nxt;
    end else if (cmd.advance) begin
      chk_r  <= addr_r;
      addr_r <= addr_inc;
      if (cmd.probe_eval) begin
        pcnt_r <= pcnt_r + 1'b1;
      end
    end
  end

  assign sts.hash_last = (hcnt_r == HCNT_W'(HASH_STEPS - 1));

  // slot tables
  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en_r) begin
      state_mem[res_slot_r] <= wr_key_r ? SLOT_LIVE : SLOT_TOMB;
      if (wr_key_r) begin
        key_mem[res_slot_r] <= key_r;
      end
    end
    rd_key_r   <= key_mem[addr_r];
    rd_state_r <= state_mem[addr_r];
    rd_valid_r <= valid_r[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.commit && wr_en_r) begin
      valid_r[res_slot_r] <= 1'b1;
    end
  end

  // probe evaluation
  assign is_insert = (mode_r == MODE_INSERT);
  assign is_delete = (mode_r == MODE_DELETE);
  assign is_empty  = !rd_valid_r || (rd_state_r == SLOT_EMPTY);
  assign is_live   = rd_valid_r && (rd_state_r == SLOT_LIVE);
  assign is_match  = is_live && (rd_key_r == key_r);
  assign hit       = is_insert ? (!is_live || is_match) : (is_empty || is_match);

  assign sts.probe_stop = hit;
  assign sts.probe_last = (pcnt_r == SLOT_W'(TABLE_SLOTS - 1));

  always_comb begin
    res_status_nxt = RES_NOT_FOUND;
    res_slot_nxt   = '0;
    wr_en_nxt      = 1'b0;
    wr_key_nxt     = 1'b0;
    if (is_insert) begin
      if (!is_live) begin
        res_status_nxt = RES_INSERTED;
        res_slot_nxt   = chk_r;
        wr_en_nxt      = 1'b1;
        wr_key_nxt     = 1'b1;
      end else if (is_match) begin
        res_status_nxt = RES_PRESENT;
      end else begin
        res_status_nxt = RES_FULL;
      end
    end else if (is_match) begin
      res_slot_nxt = chk_r;
      if (is_delete) begin
        res_status_nxt = RES_DELETED;
        wr_en_nxt      = 1'b1;
      end else begin
        res_status_nxt = RES_FOUND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.probe_eval) begin
      res_status_r <= res_status_nxt;
      res_slot_r   <= res_slot_nxt;
      wr_en_r      <= wr_en_nxt;
      wr_key_r     <= wr_key_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r.status     <= res_status_r;
      out_data_r.slot_index <= IDX_W'(res_slot_r);
      out_data_r.key_echo   <= key_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ hw/rtl/linear_probe_hash_set.sv @@
// Operation: the home slot is formed from the key magnitude, 4 key bits a cycle, after which
// the probe walks 1..43 slots from it before the out_valid strobe; start is taken only when
// busy is low, so a new item waits until the last is done. The probe reads one slot per cycle.
// Reset: synchronous, active low; clears the controller, the strobe and the slot
// valid bits, so every slot reads as empty straight after reset.
// ----------------------------------------------------------------------------
// linear_probe_hash_set
// Open addressing hash set of signed keys with linear probing and tombstones.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_probe_hash_set import lph_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  input  wire lph_in_t in_data,
  output logic         out_valid,
  output lph_out_t     out_data
);

  lph_cmd_t cmd;
  lph_sts_t sts;

  lph_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  lph_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ hw/rtl/lph_checker.sv @@
// ----------------------------------------------------------------------------
// lph_checker
// Port-level checks on the hash set, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lph_checker import lph_pkg::*; (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     start,
  input wire logic     busy,
  input wire lph_in_t  in_data,
  input wire logic     out_valid,
  input wire lph_out_t out_data
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("busy not raised after transfer");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("result outside end of item");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status <= RES_DELETED))
    else $error("illegal status code");

  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == RES_PRESENT || out_data.status == RES_FULL ||
                   out_data.status == RES_NOT_FOUND)) |-> (out_data.slot_index == '0))
    else $error("slot index set on a miss");

endmodule

bind linear_probe_hash_set lph_checker u_lph_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

`default_nettype wire

@@ tb/lph_result_checker.sv @@
// ----------------------------------------------------------------------------
// lph_result_checker
// Watches the command and result channels of the hash set, keeps its own
// copy of the slot table, works out each answer at the command transfer and
// compares it field by field with the result strobe, oldest first.
// ----------------------------------------------------------------------------
`default_nettype none

module lph_result_checker import lph_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  input  wire logic    busy,
  input  wire lph_in_t in_data,
  input  wire logic    out_valid,
  input  wire lph_out_t out_data,
  output int           fail_count,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  lph_slot_e        slot_state [TABLE_SLOTS];
  logic [KEY_W-1:0] slot_key   [TABLE_SLOTS];
  lph_out_t         due_results [$];
  int               report_count;

  function automatic int home_of(logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] mag;
    mag = k[KEY_W-1] ? (32'd0 - k) : k;
    return int'(mag % 32'(TABLE_SLOTS));
  endfunction

  // Applies one command to the table copy and returns its answer.
  function automatic lph_out_t probe_table(lph_in_t req);
    lph_out_t    res;
    int          s;
    int          n;
    logic        done;
    lph_status_e st;
    int          where;
    s     = home_of(req.key_value);
    done  = 1'b0;
    where = 0;
    if (req.mode == MODE_INSERT) begin
      st = RES_FULL;
      for (n = 0; n < TABLE_SLOTS && !done; n++) begin
        if (slot_state[s] != SLOT_LIVE) begin
          slot_state[s] = SLOT_LIVE;
          slot_key[s]   = req.key_value;
          st    = RES_INSERTED;
          where = s;
          done  = 1'b1;
        end else if (slot_key[s] == req.key_value) begin
          st   = RES_PRESENT;
          done = 1'b1;
        end
        s = (s == TABLE_SLOTS - 1) ? 0 : s + 1;
      end
    end else begin
      st = RES_NOT_FOUND;
      for (n = 0; n < TABLE_SLOTS && !done; n++) begin
        if (slot_state[s] == SLOT_EMPTY) begin
          done = 1'b1;
        end else if (slot_state[s] == SLOT_LIVE && slot_key[s] == req.key_value) begin
          done  = 1'b1;
          where = s;
          if (req.mode == MODE_DELETE) begin
            slot_state[s] = SLOT_TOMB;
            st = RES_DELETED;
          end else begin
            st = RES_FOUND;
          end
        end
        if (!done) s = (s == TABLE_SLOTS - 1) ? 0 : s + 1;
      end
    end
    res.status     = st;
    res.slot_index = IDX_W'(where);
    res.key_echo   = req.key_value;
    return res;
  endfunction

  always @(posedge clk) begin
    lph_out_t want;
    if (!rst_n) begin
      foreach (slot_state[i]) slot_state[i] = SLOT_EMPTY;
      due_results.delete();
      report_count = 0;
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (out_valid) begin
        if (due_results.size() == 0) begin
          if (report_count < 10)
            $display("unexpected result: status %0d slot %0d key %0d",
                     out_data.status, out_data.slot_index, out_data.key_echo);
          report_count++;
          fail_count <= fail_count + 1;
        end else begin
          want = due_results.pop_front();
          if (out_data.status !== want.status || out_data.slot_index !== want.slot_index ||
              out_data.key_echo !== want.key_echo) begin
            if (report_count < 10)
              $display("mismatch: exp status %0d slot %0d key %0d, got %0d %0d %0d",
                       want.status, want.slot_index, want.key_echo,
                       out_data.status, out_data.slot_index, out_data.key_echo);
            report_count++;
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) due_results.push_back(probe_table(in_data));
      pending <= due_results.size();
    end
  end

endmodule

`default_nettype wire

@@ tb/linear_probe_hash_set_tb.sv @@
// ----------------------------------------------------------------------------
// linear_probe_hash_set_tb
// Drives lookup, insert, delete and spare-mode commands into the hash set: a directed
// opening over collisions, tombstones and the extreme keys, then random
// fill, drain and mixed runs over clustered key pools under three idling
// regimes. Checking is done by lph_result_checker.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_probe_hash_set_tb import lph_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int POOL_SIZE   = 50;
  localparam int SEG_ITEMS   = 57;
  localparam int PHASE_SEGS  = 11;

  typedef enum int { SEG_FILL, SEG_DRAIN, SEG_MIX } seg_kind_e;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  lph_in_t  in_data;
  logic     out_valid;
  lph_out_t out_data;
  int       fail_count;
  int       pending;
  int       cycle_cnt;
  int       gap_pct;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  linear_probe_hash_set u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  lph_result_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial cycle_cnt = 0;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("linear_probe_hash_set_tb NOT OK");
      $finish;
    end
  end

  task automatic send_cmd(lph_mode_e mode, logic [KEY_W-1:0] key);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start             <= 1'b1;
    in_data.mode      <= mode;
    in_data.key_value <= key;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic fill_pool();
    logic [KEY_W-1:0] v;
    for (int j = 0; j < POOL_SIZE; j++) begin
      v = ($urandom_range(1) ? $urandom_range(5) : $urandom_range(TABLE_SLOTS - 1)) +
          32'(TABLE_SLOTS) * $urandom_range(49_000_000);
      key_pool[j] = $urandom_range(1) ? (32'd0 - v) : v;
    end
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
  endtask

  function automatic logic [KEY_W-1:0] pool_key();
    return key_pool[$urandom_range(POOL_SIZE - 1)];
  endfunction

  task automatic run_segment(seg_kind_e kind);
    int        base;
    int        pick;
    lph_mode_e mode;
    base = $urandom_range(POOL_SIZE - 1);
    for (int i = 0; i < SEG_ITEMS; i++) begin
      pick = $urandom_range(99);
      case (kind)
        SEG_FILL: begin
          if (pick < 75) send_cmd(MODE_INSERT, key_pool[(base + i) % POOL_SIZE]);
          else if (pick < 90) send_cmd(MODE_LOOKUP, pool_key());
          else send_cmd(MODE_DELETE, pool_key());
        end
        SEG_DRAIN: begin
          if (pick < 60) mode = MODE_DELETE;
          else if (pick < 90) mode = MODE_LOOKUP;
          else if (pick < 95) mode = MODE_INSERT;
          else mode = MODE_SPARE;
          send_cmd(mode, pool_key());
        end
        default: begin
          mode = lph_mode_e'($urandom_range(3));
          send_cmd(mode, (pick < 80) ? pool_key() : 32'($urandom()));
        end
      endcase
    end
  endtask

  initial begin
    int guard;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    gap_pct = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: collisions, tombstones, extreme keys, spare mode
    send_cmd(MODE_LOOKUP, 32'd0);
    send_cmd(MODE_INSERT, 32'd0);
    send_cmd(MODE_INSERT, 32'd0);
    send_cmd(MODE_INSERT, 32'd43);
    send_cmd(MODE_INSERT, -32'sd43);
    send_cmd(MODE_INSERT, 32'h8000_0000);
    send_cmd(MODE_INSERT, 32'h7fff_ffff);
    send_cmd(MODE_LOOKUP, 32'd43);
    send_cmd(MODE_SPARE, -32'sd43);
    send_cmd(MODE_DELETE, 32'd43);
    send_cmd(MODE_LOOKUP, -32'sd43);
    send_cmd(MODE_DELETE, 32'd43);
    send_cmd(MODE_INSERT, 32'd86);
    send_cmd(MODE_DELETE, 32'h8000_0000);
    send_cmd(MODE_LOOKUP, 32'h8000_0000);
    send_cmd(MODE_INSERT, 32'hffff_ffff);
    send_cmd(MODE_SPARE, 32'hffff_ffff);
    send_cmd(MODE_DELETE, 32'd0);
    send_cmd(MODE_LOOKUP, 32'd0);
    send_cmd(MODE_DELETE, 32'h7fff_ffff);
    send_cmd(MODE_LOOKUP, 32'h5555_aaaa);
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      gap_pct = (phase == 0) ? 13 : (phase == 1) ? 71 : 0;
      fill_pool();
      for (int seg = 0; seg < PHASE_SEGS; seg++) begin
        if (seg % 3 == 0) run_segment(SEG_FILL);
        else run_segment(seg_kind_e'($urandom_range(2)));
        if ($urandom_range(3) == 0) wait_drained();
      end
    end

    start <= 1'b0;
    guard = 0;
    while (pending != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (60) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("linear_probe_hash_set_tb OK");
    end else begin
      $display("linear_probe_hash_set_tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
